/* sv/bils_pkg.sv */
// ----------------------------------------------------------------------------
// bils_pkg
// Shared constants and operation codes for the indexed level set.
// ----------------------------------------------------------------------------
`default_nettype none

package bils_pkg;

    localparam int NUM_ENTRIES_DEF = 64;
    localparam int LEVEL_BITS_DEF  = 8;

    localparam int OP_W  = 3;
    localparam int ID_W  = 6;
    localparam int FID_W = 7;
    localparam int CNT_W = 7;

    localparam logic [FID_W-1:0] NONE_ID = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_NEXT   = 3'd3,
        OP_CLEAR  = 3'd4
    } opcode_t;

endpackage

`default_nettype wire

/* sv/bitmap_indexed_level_set_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_indexed_level_set_unit
// Level table addressed by id, with presence bitmap, count and find-next-set.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+-------------------------
//  request  | opcode, entry_id, entry_level            | start & !busy
//  result   | success, level_out, found_id,            | done, one cycle, no stall
//           | entry_count, is_empty                    |
//
//  One request a cycle; busy never rises. A request is first registered; the
//  bitmap update, find-next-set and level RAM access then act on it, and
//  their results, including the RAM read data, are registered as the result.
//  Reset clears the bitmap and count at once; the level RAM is not cleared,
//  since an entry is only read while its presence bit is set.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_indexed_level_set_unit #(
    parameter int NUM_ENTRIES = bils_pkg::NUM_ENTRIES_DEF,
    parameter int LEVEL_BITS  = bils_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [bils_pkg::OP_W-1:0]   opcode,
    input  wire logic [bils_pkg::ID_W-1:0]   entry_id,
    input  wire logic [LEVEL_BITS-1:0]       entry_level,
    output logic                             done,
    output logic                             success,
    output logic [LEVEL_BITS-1:0]            level_out,
    output logic [bils_pkg::FID_W-1:0]       found_id,
    output logic [bils_pkg::CNT_W-1:0]       entry_count,
    output logic                             is_empty
);
    import bils_pkg::*;

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // request stage
    logic                   req_valid_reg;
    logic [OP_W-1:0]        op_reg;
    logic [ID_W-1:0]        id_reg;
    logic [LEVEL_BITS-1:0]  lvl_reg;

    // state
    logic [NUM_ENTRIES-1:0] bitmap_reg, bitmap_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LEVEL_BITS-1:0]  level_mem [NUM_ENTRIES];

    // result stage
    logic                   done_reg;
    logic                   success_reg, success_next;
    logic                   hit_reg, hit_next;
    logic [FID_W-1:0]       found_reg, found_next;
    logic                   empty_reg;
    logic [LEVEL_BITS-1:0]  rd_data_reg;

    logic                   id_ok;
    logic [AW-1:0]          addr;
    logic                   present;
    logic                   nxt_hit;
    logic [AW-1:0]          nxt_idx;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= opcode;
            id_reg  <= entry_id;
            lvl_reg <= entry_level;
        end
    end

    always_comb
    begin
        id_ok   = {1'b0, id_reg} < FID_W'(NUM_ENTRIES);
        addr    = id_reg[AW-1:0];
        present = id_ok && bitmap_reg[addr];

        // lowest present id strictly above the start id
        nxt_hit = 1'b0;
        nxt_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i] && (FID_W'(i) > {1'b0, id_reg}))
            begin
                nxt_hit = 1'b1;
                nxt_idx = AW'(i);
            end
        end

        bitmap_next  = bitmap_reg;
        count_next   = count_reg;
        success_next = 1'b0;
        hit_next     = 1'b0;
        found_next   = NONE_ID;
        mem_we       = 1'b0;
        rd_addr      = addr;

        if (req_valid_reg)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (id_ok && (lvl_reg != '0))
                    begin
                        bitmap_next[addr] = 1'b1;
                        mem_we            = 1'b1;
                        if (!present)
                        begin
                            count_next   = count_reg + CNT_W'(1);
                            success_next = 1'b1;
                        end
                    end
                end
                OP_ERASE:
                begin
                    if (present)
                    begin
                        bitmap_next[addr] = 1'b0;
                        count_next        = count_reg - CNT_W'(1);
                        success_next      = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (present)
                    begin
                        success_next = 1'b1;
                        hit_next     = 1'b1;
                        found_next   = {1'b0, id_reg};
                    end
                end
                OP_NEXT:
                begin
                    rd_addr = nxt_idx;
                    if (nxt_hit)
                    begin
                        success_next = 1'b1;
                        hit_next     = 1'b1;
                        found_next   = FID_W'(nxt_idx);
                    end
                end
                OP_CLEAR:
                begin
                    bitmap_next = '0;
                    count_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // level RAM: a write on a valid insert, a read on every request, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[addr] <= lvl_reg;
        end
        if (req_valid_reg)
        begin
            rd_data_reg <= level_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            bitmap_reg <= bitmap_next;
            count_reg  <= count_next;
            done_reg   <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            success_reg <= success_next;
            hit_reg     <= hit_next;
            found_reg   <= found_next;
            empty_reg   <= (bitmap_next == '0);
        end
    end

    assign done        = done_reg;
    assign success     = success_reg;
    assign level_out   = hit_reg ? rd_data_reg : '0;
    assign found_id    = found_reg;
    assign entry_count = count_reg;
    assign is_empty    = empty_reg;

`ifndef SYNTH
    a_count_matches_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(bitmap_reg)))
        else $error("entry count out of step with presence bitmap");

    a_found_implies_success: assert property (@(posedge clk) disable iff (!rst_n)
        done && (found_id != NONE_ID) |-> success)
        else $error("id reported without success");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_found_level_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (found_id != NONE_ID) |-> (level_out != '0))
        else $error("present entry read back with zero level");

    a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("request produced no result");
`endif

endmodule

`default_nettype wire
